/* rtl/rtce_pkg.sv */
// Shared command codes, status codes and transaction types for the rectangle collision engine.
package rtce_pkg;

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_ERASE  = 3'd1;
  localparam logic [2:0] CMD_PLACE  = 3'd2;
  localparam logic [2:0] CMD_BOX    = 3'd3;
  localparam logic [2:0] CMD_CIRCLE = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  localparam logic [1:0] REG_MAP_LEFT   = 2'd0;
  localparam logic [1:0] REG_MAP_TOP    = 2'd1;
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd2;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd3;

  // at most this many hit results per query
  localparam int RESULT_CAP = 16;
  localparam int HIT_CNT_W  = 5;

  typedef struct packed {
    logic               circle;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [15:0]        sw;
    logic [15:0]        sh;
    logic [14:0]        rad;
  } query_t;

  typedef struct packed {
    logic [1:0] status;
    logic       hit;
    logic [3:0] hit_index;
    logic       last;
    logic [4:0] entry_count;
  } result_t;

endpackage

/* rtl/rtce_test.sv */
// Pipelined box and circle hit test of one stored rectangle against the current query.
module rtce_test #(
  parameter int COORD_BITS = 16,
  parameter int IDX_W      = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [IDX_W-1:0]             in_idx,
  input  logic signed [COORD_BITS-1:0] ent_left,
  input  logic signed [COORD_BITS-1:0] ent_top,
  input  logic [15:0]                  ent_w,
  input  logic [15:0]                  ent_h,
  input  rtce_pkg::query_t             qry,
  output logic                         out_valid,
  output logic [IDX_W-1:0]             out_idx,
  output logic                         out_hit,
  output logic                         active
);

  // edge width: holds left + w and px + sw exactly
  localparam int EW   = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
  localparam int DW   = EW + 1;
  localparam int SQ_W = 2 * DW;

  logic signed [EW-1:0] l_e, t_e, w_e, h_e, px_e, py_e, sw_e, sh_e;

  // stage 1: edges
  logic                 v1;
  logic [IDX_W-1:0]     idx1;
  logic signed [EW-1:0] l1, t1, r1, b1, qx2, qy2;

  // stage 2: box test and closest-point offsets
  logic                 v2;
  logic [IDX_W-1:0]     idx2;
  logic                 box2;
  logic signed [DW-1:0] dx2, dy2;
  logic signed [EW-1:0] cx_c, cy_c;

  // stage 3: squares
  logic                   v3;
  logic [IDX_W-1:0]       idx3;
  logic                   box3;
  logic signed [SQ_W-1:0] sqx3, sqy3;
  logic signed [SQ_W-1:0] sqx_c, sqy_c;
  logic [29:0]            rr3;

  logic signed [SQ_W:0]   dist_sq;

  assign l_e  = EW'(ent_left);
  assign t_e  = EW'(ent_top);
  assign w_e  = EW'(ent_w);
  assign h_e  = EW'(ent_h);
  assign px_e = EW'(qry.px);
  assign py_e = EW'(qry.py);
  assign sw_e = EW'(qry.sw);
  assign sh_e = EW'(qry.sh);

  always_comb begin
    if (px_e < l1) begin
      cx_c = l1;
    end else if (px_e > r1) begin
      cx_c = r1;
    end else begin
      cx_c = px_e;
    end
    if (py_e < t1) begin
      cy_c = t1;
    end else if (py_e > b1) begin
      cy_c = b1;
    end else begin
      cy_c = py_e;
    end
  end

  assign sqx_c   = dx2 * dx2;
  assign sqy_c   = dy2 * dy2;
  assign dist_sq = sqx3 + sqy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= in_idx;
    l1   <= l_e;
    t1   <= t_e;
    r1   <= l_e + w_e;
    b1   <= t_e + h_e;
    qx2  <= px_e + sw_e;
    qy2  <= py_e + sh_e;

    idx2 <= idx1;
    box2 <= !(l1 > qx2) && !(r1 < px_e) && !(t1 > qy2) && !(b1 < py_e);
    dx2  <= DW'(px_e) - DW'(cx_c);
    dy2  <= DW'(py_e) - DW'(cy_c);

    idx3 <= idx2;
    box3 <= box2;
    sqx3 <= sqx_c;
    sqy3 <= sqy_c;
    rr3  <= 30'(qry.rad) * 30'(qry.rad);

    out_idx <= idx3;
    out_hit <= qry.circle ? (dist_sq < $signed((SQ_W+1)'(rr3))) : box3;
  end

  assign active = v1 | v2 | v3 | out_valid;

endmodule

/* rtl/rect_table_collision_engine_core.sv */
// Rectangle table collision engine: command decode, entry memory and scan control.
//
// Commands enter on start while busy is low; the payload is sampled at that edge.
// Each result shows on strobe for one cycle; the receiver cannot stall it, so the
// block never waits on the output side.
// Append, a refused erase or place, and unused codes: one result in the next
// cycle, busy stays low, so these can follow back to back.
// Place: busy while the entry is read at the accept edge, then clamped against the
// map, then written back; the result comes with the write-back.
// Erase at index k: one entry moved down per cycle, from k + 1 to the last entry,
// through the read port and write port of the entry memory.
// Box or circle query: one memory read per stored entry, a four-stage hit test,
// then the final result. Hits come out in table order; each is held until the next
// one is known so the last can be marked.
// Map registers are written on the cfg channel (always ready); the user must write
// them only while idle; the block does not enforce it. Reset empties the table and
// restores the map to origin 0,0 and size 65535. Stored rectangles are not cleared;
// only entries below the count are read.
module rect_table_collision_engine_core #(
  parameter int MAX_ENTRIES = 16,
  parameter int COORD_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         command,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [15:0]        size_w,
  input  logic [15:0]        size_h,
  input  logic [3:0]         entry_index,
  input  logic [14:0]        radius,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               strobe,
  output logic [1:0]         status,
  output logic               hit,
  output logic [3:0]         hit_index,
  output logic               last,
  output logic [4:0]         entry_count
);

  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int ROW_W = 2 * COORD_BITS + 32;
  localparam int PW    = 20;
  localparam logic signed [31:0] C_MAX = (32'sd1 <<< (COORD_BITS - 1)) - 32'sd1;
  localparam logic signed [31:0] C_MIN = -(32'sd1 <<< (COORD_BITS - 1));

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ERASE = 3'd1;
  localparam logic [2:0] S_PL_A  = 3'd2;
  localparam logic [2:0] S_PL_B  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;

  function automatic logic signed [COORD_BITS-1:0] sat_c(input logic signed [31:0] v);
    if (v > C_MAX) begin
      return COORD_BITS'(C_MAX);
    end else if (v < C_MIN) begin
      return COORD_BITS'(C_MIN);
    end
    return COORD_BITS'(v);
  endfunction

  function automatic rtce_pkg::result_t mk_res(input logic [1:0] st, input logic h,
                                               input logic [3:0] idx, input logic lst,
                                               input logic [4:0] cnt);
    rtce_pkg::result_t r;
    r.status      = st;
    r.hit         = h;
    r.hit_index   = idx;
    r.last        = lst;
    r.entry_count = cnt;
    return r;
  endfunction

  // entry memory: {left, top, w, h}
  logic [ROW_W-1:0] mem [MAX_ENTRIES];
  logic [ROW_W-1:0] rdata;
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [ROW_W-1:0] wr_data;

  logic [2:0]        state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     rd_ptr;
  logic              wr_pend;
  logic [AW-1:0]     wr_addr_q;
  logic              rd_v;
  logic [AW-1:0]     rd_idx;
  logic              pend_v;
  logic [AW-1:0]     pend_idx;
  logic [rtce_pkg::HIT_CNT_W-1:0] hit_cnt;
  rtce_pkg::query_t  qry;
  rtce_pkg::result_t res;

  logic signed [15:0] map_left, map_top;
  logic [15:0]        map_width, map_height;

  // place datapath
  logic [AW-1:0]        pl_idx;
  logic signed [PW-1:0] plo_x, plo_y, hi_x, hi_y;
  logic [15:0]          pl_w, pl_h;
  logic signed [PW-1:0] px_e, py_e, lx_e, ty_e, mw_e, mh_e, w_e, h_e;
  logic signed [PW-1:0] fin_x, fin_y;

  logic accept, idx_ok, room, more;

  logic                   t_valid, t_hit, t_active;
  logic [AW-1:0]          t_idx;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign idx_ok    = (CW + 4)'(entry_index) < (CW + 4)'(count);
  assign room      = count < CW'(MAX_ENTRIES);
  assign more      = rd_ptr < count;

  assign px_e = PW'(qry.px);
  assign py_e = PW'(qry.py);
  assign lx_e = PW'(map_left);
  assign ty_e = PW'(map_top);
  assign mw_e = PW'(map_width);
  assign mh_e = PW'(map_height);
  assign w_e  = PW'(pl_w);
  assign h_e  = PW'(pl_h);

  // the upper-edge rule wins over the lower-edge rule
  assign fin_x = (plo_x + w_e > hi_x) ? (hi_x - w_e) : plo_x;
  assign fin_y = (plo_y + h_e > hi_y) ? (hi_y - h_e) : plo_y;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state)
      S_IDLE: begin
        if (accept && command == rtce_pkg::CMD_APPEND && room) begin
          wr_en   = 1'b1;
          wr_addr = AW'(count);
          wr_data = {sat_c(32'(pos_x)), sat_c(32'(pos_y)), size_w, size_h};
        end
        if (accept && command == rtce_pkg::CMD_PLACE && idx_ok) begin
          rd_en   = 1'b1;
          rd_addr = AW'(entry_index);
        end
      end
      S_ERASE: begin
        if (more) begin
          rd_en   = 1'b1;
          rd_addr = AW'(rd_ptr);
        end
        if (wr_pend) begin
          wr_en   = 1'b1;
          wr_addr = wr_addr_q;
          wr_data = rdata;
        end
      end
      S_SCAN: begin
        if (more) begin
          rd_en   = 1'b1;
          rd_addr = AW'(rd_ptr);
        end
      end
      S_PL_B: begin
        wr_en   = 1'b1;
        wr_addr = pl_idx;
        wr_data = {sat_c(32'(fin_x)), sat_c(32'(fin_y)), pl_w, pl_h};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_left   <= '0;
      map_top    <= '0;
      map_width  <= 16'hFFFF;
      map_height <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rtce_pkg::REG_MAP_LEFT:   map_left   <= cfg_data;
        rtce_pkg::REG_MAP_TOP:    map_top    <= cfg_data;
        rtce_pkg::REG_MAP_WIDTH:  map_width  <= cfg_data;
        rtce_pkg::REG_MAP_HEIGHT: map_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rtce_test #(
    .COORD_BITS (COORD_BITS),
    .IDX_W      (AW)
  ) u_test (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_v),
    .in_idx    (rd_idx),
    .ent_left  (rdata[ROW_W-1 -: COORD_BITS]),
    .ent_top   (rdata[ROW_W-COORD_BITS-1 -: COORD_BITS]),
    .ent_w     (rdata[31:16]),
    .ent_h     (rdata[15:0]),
    .qry       (qry),
    .out_valid (t_valid),
    .out_idx   (t_idx),
    .out_hit   (t_hit),
    .active    (t_active)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      strobe  <= 1'b0;
      wr_pend <= 1'b0;
      rd_v    <= 1'b0;
      pend_v  <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            qry.circle <= (command == rtce_pkg::CMD_CIRCLE);
            qry.px     <= pos_x;
            qry.py     <= pos_y;
            qry.sw     <= size_w;
            qry.sh     <= size_h;
            qry.rad    <= radius;
            case (command)
              rtce_pkg::CMD_APPEND: begin
                strobe <= 1'b1;
                if (room) begin
                  count <= count + 1'b1;
                  res   <= mk_res(rtce_pkg::ST_OK, 1'b0, 4'd0, 1'b1, 5'(count + 1'b1));
                end else begin
                  res   <= mk_res(rtce_pkg::ST_FULL, 1'b0, 4'd0, 1'b1, 5'(count));
                end
              end
              rtce_pkg::CMD_ERASE: begin
                if (idx_ok) begin
                  rd_ptr  <= CW'(entry_index) + 1'b1;
                  wr_pend <= 1'b0;
                  state   <= S_ERASE;
                end else begin
                  strobe <= 1'b1;
                  res    <= mk_res(rtce_pkg::ST_BAD_INDEX, 1'b0, 4'd0, 1'b1, 5'(count));
                end
              end
              rtce_pkg::CMD_PLACE: begin
                if (idx_ok) begin
                  pl_idx <= AW'(entry_index);
                  state  <= S_PL_A;
                end else begin
                  strobe <= 1'b1;
                  res    <= mk_res(rtce_pkg::ST_BAD_INDEX, 1'b0, 4'd0, 1'b1, 5'(count));
                end
              end
              rtce_pkg::CMD_BOX, rtce_pkg::CMD_CIRCLE: begin
                rd_ptr  <= '0;
                rd_v    <= 1'b0;
                pend_v  <= 1'b0;
                hit_cnt <= '0;
                state   <= S_SCAN;
              end
              default: begin
                strobe <= 1'b1;
                res    <= mk_res(rtce_pkg::ST_OK, 1'b0, 4'd0, 1'b1, 5'(count));
              end
            endcase
          end
        end
        S_ERASE: begin
          // read entry j, write it to j - 1 in the following cycle
          if (more) begin
            rd_ptr    <= rd_ptr + 1'b1;
            wr_pend   <= 1'b1;
            wr_addr_q <= AW'(rd_ptr - 1'b1);
          end else begin
            wr_pend <= 1'b0;
            if (!wr_pend) begin
              count  <= count - 1'b1;
              strobe <= 1'b1;
              res    <= mk_res(rtce_pkg::ST_OK, 1'b0, 4'd0, 1'b1, 5'(count - 1'b1));
              state  <= S_IDLE;
            end
          end
        end
        S_PL_A: begin
          plo_x <= (px_e < lx_e) ? lx_e : px_e;
          plo_y <= (py_e < ty_e) ? ty_e : py_e;
          hi_x  <= lx_e + mw_e;
          hi_y  <= ty_e + mh_e;
          pl_w  <= rdata[31:16];
          pl_h  <= rdata[15:0];
          state <= S_PL_B;
        end
        S_PL_B: begin
          strobe <= 1'b1;
          res    <= mk_res(rtce_pkg::ST_OK, 1'b0, 4'd0, 1'b1, 5'(count));
          state  <= S_IDLE;
        end
        S_SCAN: begin
          rd_v   <= more;
          rd_idx <= AW'(rd_ptr);
          if (more) begin
            rd_ptr <= rd_ptr + 1'b1;
          end
          if (t_valid && t_hit && hit_cnt < rtce_pkg::HIT_CNT_W'(rtce_pkg::RESULT_CAP)) begin
            // the held hit is not the last one: release it now
            if (pend_v) begin
              strobe <= 1'b1;
              res    <= mk_res(rtce_pkg::ST_OK, 1'b1, 4'(pend_idx), 1'b0, 5'(count));
            end
            pend_v   <= 1'b1;
            pend_idx <= t_idx;
            hit_cnt  <= hit_cnt + 1'b1;
          end
          if (!more && !rd_v && !t_active) begin
            strobe <= 1'b1;
            if (pend_v) begin
              res <= mk_res(rtce_pkg::ST_OK, 1'b1, 4'(pend_idx), 1'b1, 5'(count));
            end else begin
              res <= mk_res(rtce_pkg::ST_OK, 1'b0, 4'd0, 1'b1, 5'(count));
            end
            pend_v <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status      = res.status;
  assign hit         = res.hit;
  assign hit_index   = res.hit_index;
  assign last        = res.last;
  assign entry_count = res.entry_count;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_hit_in_table: assert property (@(posedge clk) disable iff (rst)
    strobe && hit |-> (CW + 4)'(hit_index) < (CW + 4)'(count))
    else $error("hit index outside the table");

  a_done_has_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> strobe)
    else $error("command finished without a result");

  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    wr_en && rd_en |-> wr_addr != rd_addr)
    else $error("read and write hit the same entry");
`endif

endmodule
